>>> rtl/tcm_pkg.sv
package tcm_pkg;

  localparam int SAMPLES_PER_CORNER_D = 10;
  localparam int EDGE_MARGIN_D        = 20;
  localparam int MARKER_SIZE_D        = 10;
  localparam int RAW_BITS_D           = 12;

  localparam int DIV_BITS = 24;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SAMPLE  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/tcm_divider.sv
module tcm_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcm_pkg::div_req_t                 req,
  output logic                              busy,
  output logic [tcm_pkg::DIV_BITS-1:0]      quotient
);

  localparam int W = tcm_pkg::DIV_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> cnt_r == CW'(W)) else $error("divider start lost");

endmodule

>>> rtl/touch_calibrate_and_map.sv
// Channel | Dir | Fields (low bit first)
// in_     | in  | tdata: op, raw_x, raw_y, raw_z
// out_    | out | tdata: touch_valid, point_x, point_y, calibrating, calib_corner,
//         |     |        sample_taken, calibration_done
// cfg_    | in  | APB registers: threshold 0x0, width 0x4, height 0x8
// A mapped touch runs two 24-step passes of the shared restoring divider, X then Y,
// each closed by a hand-over with the divider idle; ST_OUT then registers the result.
// The next item is accepted only once that result has been taken.
// Every other item has its result registered in the cycle after it is accepted.
// Reset is synchronous; no clearing pass is needed.
// The input is not ready while an item is at work or its result waits unread.
module touch_calibrate_and_map #(
  parameter int SAMPLES_PER_CORNER = tcm_pkg::SAMPLES_PER_CORNER_D,
  parameter int EDGE_MARGIN        = tcm_pkg::EDGE_MARGIN_D,
  parameter int MARKER_SIZE        = tcm_pkg::MARKER_SIZE_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op, raw_x, raw_y, raw_z, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // touch_valid, point_x, point_y, calibrating,
                                  // calib_corner, sample_taken, calibration_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int W = tcm_pkg::DIV_BITS;
  localparam int OUT_LO = EDGE_MARGIN + MARKER_SIZE / 2;
  localparam logic [11:0] RAW_MASK = 12'((1 << tcm_pkg::RAW_BITS_D) - 1);
  // Reciprocal of the sample count, scaled by 2^20, rounded up.
  localparam longint RECIP_L = ((longint'(1) << 20) + SAMPLES_PER_CORNER - 1) /
                               SAMPLES_PER_CORNER;
  localparam logic [20:0] RECIP = 21'(RECIP_L);

  logic [11:0] thr_r;
  logic [9:0]  sw_r, sh_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 12'd300;
      sw_r  <= 10'd320;
      sh_r  <= 10'd240;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        tcm_pkg::REG_THRESHOLD: thr_r <= cfg_pwdata[11:0];
        tcm_pkg::REG_WIDTH:     sw_r  <= cfg_pwdata[9:0];
        tcm_pkg::REG_HEIGHT:    sh_r  <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      tcm_pkg::REG_THRESHOLD: cfg_prdata = {20'd0, thr_r};
      tcm_pkg::REG_WIDTH:     cfg_prdata = {22'd0, sw_r};
      tcm_pkg::REG_HEIGHT:    cfg_prdata = {22'd0, sh_r};
      default:                cfg_prdata = '0;
    endcase
  end

  logic        in_op;
  logic [11:0] in_rx, in_ry, in_rz;
  assign in_op = in_tdata[0];
  assign in_rx = in_tdata[12:1] & RAW_MASK;
  assign in_ry = in_tdata[24:13] & RAW_MASK;
  assign in_rz = in_tdata[36:25];

  tcm_pkg::state_t st_r, st_nxt;
  tcm_pkg::phase_t ph_r;
  logic [1:0]  corner_r;
  logic [3:0]  cnt_r;
  logic [15:0] sumx_r, sumy_r;
  logic [11:0] avg_x [4];
  logic [11:0] avg_y [4];
  logic        swap_r;
  logic [11:0] minx_r, maxx_r, miny_r, maxy_r;
  logic [1:0]  flip_r;

  // Mapping operands held across the divides.
  logic        negx_r, negy_r;
  logic [W-1:0] magy_r, spany_r;
  logic [W-1:0] qx_r;

  logic [39:0] res_r;
  logic        ovalid_r;

  tcm_pkg::div_req_t dreq;
  logic              dbusy;
  logic [W-1:0]      dq;

  tcm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quotient(dq));

  logic accept;
  assign in_tready = (st_r == tcm_pkg::ST_IDLE) && !ovalid_r;
  assign accept    = in_tvalid && in_tready;

  // Signed product (raw - lo) * (out_hi - out_lo) for each axis.
  logic [11:0] axr, ayr;
  logic signed [13:0] dxr, dyr;
  logic signed [11:0] tgx, tgy;
  logic signed [25:0] prx, pry;
  always_comb begin
    axr = swap_r ? in_ry : in_rx;
    ayr = swap_r ? in_rx : in_ry;
    dxr = $signed({2'b0, axr}) - $signed({2'b0, minx_r});
    dyr = $signed({2'b0, ayr}) - $signed({2'b0, miny_r});
    tgx = $signed({2'b0, sw_r}) - 12'(2 * OUT_LO);
    tgy = $signed({2'b0, sh_r}) - 12'(2 * OUT_LO);
    prx = dxr * tgx;
    pry = dyr * tgy;
  end

  function automatic logic [W-1:0] mag(input logic signed [25:0] v);
    logic signed [25:0] a;
    a = v < 0 ? -v : v;
    return a[W-1:0];
  endfunction

  function automatic logic [15:0] finish(input logic [W-1:0] q, input logic neg,
                                         input logic zero, input logic [9:0] size,
                                         input logic flip);
    logic signed [25:0] v;
    v = zero ? 26'(OUT_LO) : ((neg ? -$signed({2'b0, q}) : $signed({2'b0, q}))
        + 26'(OUT_LO));
    if (flip) v = $signed({16'd0, size}) - v;
    if (v > 26'sd32767) v = 26'sd32767;
    if (v < -26'sd32768) v = -26'sd32768;
    return v[15:0];
  endfunction

  logic zx_r, zy_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tcm_pkg::ST_IDLE: if (accept && !in_op && ph_r == tcm_pkg::PH_IDLE &&
                            !(in_rz < thr_r)) st_nxt = tcm_pkg::ST_DIVX;
      tcm_pkg::ST_DIVX: if (!dbusy) st_nxt = tcm_pkg::ST_DIVY;
      tcm_pkg::ST_DIVY: if (!dbusy) st_nxt = tcm_pkg::ST_OUT;
      tcm_pkg::ST_OUT:  st_nxt = tcm_pkg::ST_IDLE;
      default:          st_nxt = tcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dreq = '0;
    if (st_r == tcm_pkg::ST_IDLE && st_nxt == tcm_pkg::ST_DIVX) begin
      dreq.start    = 1'b1;
      dreq.dividend = mag(prx);
      dreq.divisor  = {12'd0, maxx_r - minx_r};
    end else if (st_r == tcm_pkg::ST_DIVX && !dbusy) begin
      dreq.start    = 1'b1;
      dreq.dividend = magy_r;
      dreq.divisor  = spany_r;
    end
  end

  // Derivation from the stored corner averages.
  logic [11:0] c0x, c1x, c2x, c3x, c0y, c1y, c2y, c3y;
  logic [11:0] d0, d1;
  logic        sw;
  logic [11:0] bx0, bx1, by0, by1;
  always_comb begin
    d0 = avg_x[0] > avg_x[1] ? avg_x[0] - avg_x[1] : avg_x[1] - avg_x[0];
    d1 = avg_y[0] > avg_y[1] ? avg_y[0] - avg_y[1] : avg_y[1] - avg_y[0];
    sw = d0 > d1;
    c0x = sw ? avg_y[0] : avg_x[0];  c0y = sw ? avg_x[0] : avg_y[0];
    c1x = sw ? avg_y[1] : avg_x[1];  c1y = sw ? avg_x[1] : avg_y[1];
    c2x = sw ? avg_y[2] : avg_x[2];  c2y = sw ? avg_x[2] : avg_y[2];
    c3x = sw ? avg_y[3] : avg_x[3];  c3y = sw ? avg_x[3] : avg_y[3];
    bx0 = 12'(({1'b0, c0x} + {1'b0, c1x}) >> 1);
    bx1 = 12'(({1'b0, c2x} + {1'b0, c3x}) >> 1);
    by0 = 12'(({1'b0, c0y} + {1'b0, c2y}) >> 1);
    by1 = 12'(({1'b0, c1y} + {1'b0, c3y}) >> 1);
  end

  logic [15:0] nsx, nsy;
  logic [3:0]  ncnt;
  logic [36:0] qsx, qsy;
  assign nsx  = sumx_r + {4'd0, in_rx};
  assign nsy  = sumy_r + {4'd0, in_ry};
  assign ncnt = cnt_r + 1'b1;
  // The scaled reciprocal is exact for every sum that the 16-bit registers can hold.
  assign qsx  = 37'(nsx) * 37'(RECIP);
  assign qsy  = 37'(nsy) * 37'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tcm_pkg::ST_IDLE;
      ph_r <= tcm_pkg::PH_IDLE;
      corner_r <= '0;
      cnt_r <= '0;
      sumx_r <= '0;
      sumy_r <= '0;
      swap_r <= 1'b0;
      minx_r <= '0;
      miny_r <= '0;
      maxx_r <= RAW_MASK;
      maxy_r <= RAW_MASK;
      flip_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      if (accept) begin
        res_r <= '0;
        if (in_op) begin
          ph_r <= tcm_pkg::PH_SAMPLE;
          corner_r <= '0; cnt_r <= '0; sumx_r <= '0; sumy_r <= '0;
          res_r[33] <= 1'b1;
          ovalid_r <= 1'b1;
        end else if (ph_r == tcm_pkg::PH_SAMPLE) begin
          res_r[33] <= 1'b1;
          res_r[35:34] <= corner_r;
          if (in_rz > thr_r) begin
            sumx_r <= nsx; sumy_r <= nsy; cnt_r <= ncnt;
            res_r[36] <= 1'b1;
            if (32'(ncnt) >= SAMPLES_PER_CORNER) begin
              avg_x[corner_r] <= qsx[31:20];
              avg_y[corner_r] <= qsy[31:20];
              ph_r <= tcm_pkg::PH_RELEASE;
            end
          end
          ovalid_r <= 1'b1;
        end else if (ph_r == tcm_pkg::PH_RELEASE) begin
          res_r[33] <= 1'b1;
          res_r[35:34] <= corner_r;
          if (!(in_rz > thr_r)) begin
            cnt_r <= '0; sumx_r <= '0; sumy_r <= '0;
            if (corner_r == 2'd3) begin
              swap_r <= sw;
              minx_r <= bx0 > bx1 ? bx1 : bx0;
              maxx_r <= bx0 > bx1 ? bx0 : bx1;
              miny_r <= by0 > by1 ? by1 : by0;
              maxy_r <= by0 > by1 ? by0 : by1;
              flip_r <= {by0 > by1, bx0 > bx1};
              corner_r <= '0;
              ph_r <= tcm_pkg::PH_IDLE;
              res_r[33] <= 1'b0;
              res_r[35:34] <= '0;
              res_r[37] <= 1'b1;
            end else begin
              corner_r <= corner_r + 1'b1;
              res_r[35:34] <= corner_r + 1'b1;
              ph_r <= tcm_pkg::PH_SAMPLE;
            end
          end
          ovalid_r <= 1'b1;
        end else if (st_nxt == tcm_pkg::ST_IDLE) begin
          ovalid_r <= 1'b1;
        end
      end
      if (st_r == tcm_pkg::ST_OUT) begin
        res_r[0] <= 1'b1;
        res_r[16:1] <= finish(qx_r, negx_r, zx_r, sw_r, flip_r[0]);
        res_r[32:17] <= finish(dq, negy_r, zy_r, sh_r, flip_r[1]);
        ovalid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == tcm_pkg::ST_IDLE) begin
      negx_r  <= prx < 0;
      negy_r  <= pry < 0;
      zx_r    <= maxx_r == minx_r;
      zy_r    <= maxy_r == miny_r;
      magy_r  <= mag(pry);
      spany_r <= {12'd0, maxy_r - miny_r};
    end
    if (st_r == tcm_pkg::ST_DIVX && !dbusy) qx_r <= dq;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != tcm_pkg::ST_IDLE) |-> !in_tready) else $error("accepted while mapping");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_phase_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == tcm_pkg::PH_IDLE) |-> corner_r == 2'd0) else $error("stray corner");
  a_map_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == tcm_pkg::ST_DIVX) |-> ph_r == tcm_pkg::PH_IDLE) else $error("map in calib");

endmodule
